[rtl/led_ripple_ring_shader_top_defines.svh]
// Assertion macros for the checker file of the ripple shader.
`ifndef LED_RIPPLE_RING_SHADER_TOP_DEFINES_SVH
`define LED_RIPPLE_RING_SHADER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ripple shader check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ripple shader check failed");

`endif

[rtl/lrrs_pkg.sv]
`default_nettype none
package lrrs_pkg;

	// Fraction bits of positions and radii; ONE_VAL stands for 1.0.
	localparam int COORD_BITS = 10;
	localparam int ONE_VAL = 1 << COORD_BITS;

	localparam int DEF_MAX_RIPPLES = 16;

	// Configuration port.
	localparam int CFG_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int LIMIT_W = 5;
	localparam int INTENS_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTENSITY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd3;

	localparam logic [COORD_BITS-1:0] RST_RADIUS_STEP = 10'd5;
	localparam logic [COORD_BITS-1:0] RST_BAND_WIDTH = 10'd102;
	localparam logic [INTENS_W-1:0] RST_INTENSITY = 8'd179;
	localparam logic [LIMIT_W-1:0] RST_LIMIT = 5'd8;

	// Command codes.
	localparam logic [1:0] CMD_SHADE = 2'd0;
	localparam logic [1:0] CMD_SPAWN = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} colour_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
		logic [7:0] spawn_red;
		logic [7:0] spawn_green;
		logic [7:0] spawn_blue;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} result_t;

	// One entry of the ripple table.
	typedef struct packed {
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [COORD_BITS-1:0] radius;
		colour_t colour;
	} ripple_t;

endpackage
`default_nettype wire

[rtl/led_ripple_ring_shader_top.sv]
`default_nettype none
// Ripple ring shader. The block keeps a table of up to MAX_RIPPLES expanding rings and
// takes one command at a time: an item is transferred at a rising edge where start is
// high and busy is low. A shade command returns one pixel colour on result, marked by
// done for exactly one cycle; the receiver cannot stall, so it must take the transfer
// in that cycle. Spawn and tick commands return nothing, and neither does command 3.
// Shade and tick walk the table one slot per cycle through a small shared datapath
// (table read, squares and weight, band test and channel products, accumulate), and
// busy stays high until the last slot has passed the accumulate step; done comes in
// the cycle busy falls. A spawn scans for the lowest free slot; when the table already
// holds the limit or is full, the spawn is dropped and busy stays low. The table itself is a
// memory with one read and one write port; the alive marks and the ripple count are
// flip-flops cleared by reset, so no clearing pass is needed. The user must write the
// configuration via wr_en, wr_idx and wr_data while busy is low; the block does not check.
module led_ripple_ring_shader_top #(
	parameter int MAX_RIPPLES = lrrs_pkg::DEF_MAX_RIPPLES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  lrrs_pkg::item_t               item,
	output logic                          busy,
	output logic                          done,
	output lrrs_pkg::result_t             result,
	input  logic                          wr_en,
	input  logic [lrrs_pkg::CFG_IDX_W-1:0] wr_idx,
	input  logic [lrrs_pkg::CFG_W-1:0]     wr_data
);
	import lrrs_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int IDX_W = (MAX_RIPPLES > 1) ? $clog2(MAX_RIPPLES) : 1;
	localparam int CNT_W = $clog2(MAX_RIPPLES + 1);
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int SQ_W = 2 * CB;
	localparam int WGT_W = INTENS_W + CB + 1;
	localparam int PROD_W = WGT_W + 8;
	localparam int SHIFT = 8 + CB;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SHADE = 4'b0010,
		ST_TICK  = 4'b0100,
		ST_SPAWN = 4'b1000
	} state_t;

	// Control state.
	state_t state_q;
	logic [CNT_W-1:0] slot_q;
	logic [CNT_W-1:0] count_q;
	logic [MAX_RIPPLES-1:0] alive_q;
	logic done_q;

	// Configuration registers.
	logic [CB-1:0] step_q;
	logic [CB-1:0] band_q;
	logic [INTENS_W-1:0] intens_q;
	logic [LIMIT_W-1:0] limit_q;

	// The accepted command is held for the whole walk.
	item_t item_q;

	ripple_t ripple_mem_q [MAX_RIPPLES];

	// Stage 1: table entry read for one slot.
	logic v_s1;
	logic [IDX_W-1:0] slot_s1;
	logic alive_s1;
	ripple_t rd_s1;

	// Stage 2: squares and weight.
	logic v_s2;
	logic alive_s2;
	logic inner_s2;
	logic [SQ_W-1:0] dxsq_s2;
	logic [SQ_W-1:0] dysq_s2;
	logic [SQ_W-1:0] rsq_s2;
	logic [SQ_W-1:0] innersq_s2;
	logic [WGT_W-1:0] weight_s2;
	colour_t colour_s2;

	// Stage 3: band test and per-channel contributions.
	logic v_s3;
	logic hit_s3;
	colour_t contrib_s3;

	colour_t acc_q;
	result_t result_q;

	logic [IDX_W-1:0] slot_idx;
	logic issue;
	logic walking;
	logic drained;
	logic finish;
	logic spawn_full;
	logic spawn_here;
	logic [CB:0] new_r;
	logic tick_write;
	logic retire;
	logic mem_we;
	logic [IDX_W-1:0] mem_waddr;
	ripple_t mem_wdata;
	logic [CB-1:0] dx;
	logic [CB-1:0] dy;
	logic [CB-1:0] inner;
	logic [SQ_W:0] d2;
	logic hit;
	logic [PROD_W-1:0] prod_r;
	logic [PROD_W-1:0] prod_g;
	logic [PROD_W-1:0] prod_b;
	logic [8:0] sum_r;
	logic [8:0] sum_g;
	logic [8:0] sum_b;

	assign slot_idx = slot_q[IDX_W-1:0];
	assign walking = (state_q == ST_SHADE) || (state_q == ST_TICK);
	assign issue = walking && (slot_q != CNT_W'(MAX_RIPPLES));
	assign drained = !v_s1 && !v_s2 && !v_s3;
	assign finish = walking && !issue && drained;

	// A spawn is dropped when the count has reached the limit or the table is full.
	assign spawn_full = (CMP_W'(count_q) >= CMP_W'(limit_q)) ||
		(count_q >= CNT_W'(MAX_RIPPLES));
	assign spawn_here = (state_q == ST_SPAWN) && !alive_q[slot_idx];

	// Tick: grow the radius and retire the ring once it reaches 1.0.
	assign new_r = {1'b0, rd_s1.radius} + {1'b0, step_q};
	assign tick_write = (state_q == ST_TICK) && v_s1 && alive_s1 && !new_r[CB];
	assign retire = (state_q == ST_TICK) && v_s1 && alive_s1 && new_r[CB];

	always_comb begin
		mem_we = spawn_here || tick_write;
		mem_waddr = slot_s1;
		mem_wdata = rd_s1;
		mem_wdata.radius = new_r[CB-1:0];
		if (spawn_here) begin
			mem_waddr = slot_idx;
			mem_wdata.cx = item_q.pos_x;
			mem_wdata.cy = item_q.pos_y;
			mem_wdata.radius = '0;
			mem_wdata.colour.red = item_q.spawn_red;
			mem_wdata.colour.green = item_q.spawn_green;
			mem_wdata.colour.blue = item_q.spawn_blue;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ripple_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_s1 <= ripple_mem_q[slot_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q <= '0;
			count_q <= '0;
			alive_q <= '0;
			done_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			step_q <= RST_RADIUS_STEP;
			band_q <= RST_BAND_WIDTH;
			intens_q <= RST_INTENSITY;
			limit_q <= RST_LIMIT;
		end else begin
			done_q <= 1'b0;
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;

			if (wr_en) begin
				case (wr_idx)
					REG_RADIUS_STEP: step_q <= wr_data[CB-1:0];
					REG_BAND_WIDTH:  band_q <= wr_data[CB-1:0];
					REG_INTENSITY:   intens_q <= wr_data[INTENS_W-1:0];
					REG_LIMIT:       limit_q <= wr_data[LIMIT_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					slot_q <= '0;
					if (start) begin
						case (item.cmd)
							CMD_SHADE: state_q <= ST_SHADE;
							CMD_TICK:  state_q <= ST_TICK;
							CMD_SPAWN: begin
								if (!spawn_full) begin
									state_q <= ST_SPAWN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SHADE, ST_TICK: begin
					if (issue) begin
						slot_q <= slot_q + CNT_W'(1);
					end else if (drained) begin
						state_q <= ST_IDLE;
						done_q <= (state_q == ST_SHADE);
					end
				end
				ST_SPAWN: begin
					// A free slot always exists here because the count is below the size.
					if (spawn_here) begin
						alive_q[slot_idx] <= 1'b1;
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_IDLE;
					end else begin
						slot_q <= slot_q + CNT_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (retire) begin
				alive_q[slot_s1] <= 1'b0;
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Stage 1 to 2: distances, squares and the brightness weight of the ring.
	always_comb begin
		dx = (item_q.pos_x >= rd_s1.cx) ? item_q.pos_x - rd_s1.cx : rd_s1.cx - item_q.pos_x;
		dy = (item_q.pos_y >= rd_s1.cy) ? item_q.pos_y - rd_s1.cy : rd_s1.cy - item_q.pos_y;
		inner = (rd_s1.radius > band_q) ? rd_s1.radius - band_q : '0;
	end

	// Stage 2 to 3: exact band test on squared distances and the channel products.
	assign d2 = {1'b0, dxsq_s2} + {1'b0, dysq_s2};
	assign hit = alive_s2 && (d2 < {1'b0, rsq_s2}) &&
		(!inner_s2 || (d2 > {1'b0, innersq_s2}));
	assign prod_r = PROD_W'(weight_s2) * PROD_W'(colour_s2.red);
	assign prod_g = PROD_W'(weight_s2) * PROD_W'(colour_s2.green);
	assign prod_b = PROD_W'(weight_s2) * PROD_W'(colour_s2.blue);

	// Stage 3: saturating accumulation.
	assign sum_r = {1'b0, acc_q.red} + {1'b0, contrib_s3.red};
	assign sum_g = {1'b0, acc_q.green} + {1'b0, contrib_s3.green};
	assign sum_b = {1'b0, acc_q.blue} + {1'b0, contrib_s3.blue};

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
		end

		slot_s1 <= slot_idx;
		alive_s1 <= alive_q[slot_idx];

		alive_s2 <= alive_s1;
		inner_s2 <= (rd_s1.radius > band_q);
		dxsq_s2 <= SQ_W'(dx) * SQ_W'(dx);
		dysq_s2 <= SQ_W'(dy) * SQ_W'(dy);
		rsq_s2 <= SQ_W'(rd_s1.radius) * SQ_W'(rd_s1.radius);
		innersq_s2 <= SQ_W'(inner) * SQ_W'(inner);
		weight_s2 <= WGT_W'(intens_q) * (WGT_W'(ONE_VAL) - WGT_W'(rd_s1.radius));
		colour_s2 <= rd_s1.colour;

		hit_s3 <= hit;
		contrib_s3.red <= prod_r[SHIFT+7:SHIFT];
		contrib_s3.green <= prod_g[SHIFT+7:SHIFT];
		contrib_s3.blue <= prod_b[SHIFT+7:SHIFT];

		if (start && !busy) begin
			acc_q <= '0;
		end else if (v_s3 && hit_s3) begin
			acc_q.red <= sum_r[8] ? 8'hFF : sum_r[7:0];
			acc_q.green <= sum_g[8] ? 8'hFF : sum_g[7:0];
			acc_q.blue <= sum_b[8] ? 8'hFF : sum_b[7:0];
		end

		if (finish) begin
			result_q.red <= acc_q.red;
			result_q.green <= acc_q.green;
			result_q.blue <= acc_q.blue;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

[rtl/lrrs_checker.sv]
`default_nettype none
`include "led_ripple_ring_shader_top_defines.svh"
module lrrs_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input lrrs_pkg::item_t item,
	input logic            busy,
	input logic            done
);
	import lrrs_pkg::*;

	logic taken;
	assign taken = start && !busy;

	// A shade transfer always starts a walk of the table.
	`LRRS_ASSERT_NEXT(a_shade_busy, clk, arst_n, taken && (item.cmd == CMD_SHADE), busy)

	// Spawn, tick and unknown commands never produce a result right after the transfer.
	`LRRS_ASSERT_NEXT(a_no_result, clk, arst_n, taken && (item.cmd != CMD_SHADE), !done)

	// The result appears as busy falls, never while a command is still running.
	`LRRS_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy && $past(busy))

	// The strobe lasts one cycle.
	`LRRS_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)

endmodule

bind led_ripple_ring_shader_top lrrs_checker u_lrrs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.item(item),
	.busy(busy),
	.done(done)
);
`default_nettype wire
